>>> src/counting_semaphore_table_unit_assert.svh
// ----------------------------------------------------------------------------
// counting semaphore table assertion macros
// shared property forms for the table's controller and datapath
// ----------------------------------------------------------------------------
`ifndef COUNTING_SEMAPHORE_TABLE_UNIT_ASSERT_SVH
`define COUNTING_SEMAPHORE_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CSEM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csem assertion failed");

// next-cycle implication, disabled in reset
`define CSEM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csem assertion failed");

`endif

>>> src/csem_pkg.sv
// ----------------------------------------------------------------------------
// csem_pkg
// types and constants shared by the semaphore table modules
// ----------------------------------------------------------------------------
`default_nettype none

package csem_pkg;

   // entries per priority-encoder group, as log2
   localparam int GRP_BITS = 5;

   typedef enum logic [2:0] {
      FN_OPEN      = 3'd0,
      FN_CLOSE     = 3'd1,
      FN_UP        = 3'd2,
      FN_DOWN      = 3'd3,
      FN_OPEN_FREE = 3'd4
   } csem_func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_ERR   = 2'd1,
      ST_BLOCK = 2'd2
   } csem_status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_READ = 2'd1,
      S_EXEC = 2'd2
   } csem_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;    // latch request word, start count read
      logic scan;    // sample active bit, first group search stage
      logic commit;  // update table, load result word
   } csem_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic slot_free;  // result register can take a word this cycle
   } csem_sts_type;

endpackage

`default_nettype wire

>>> src/csem_ctrl.sv
// ----------------------------------------------------------------------------
// csem_ctrl
// sequencer for one command: accept, read, execute
// ----------------------------------------------------------------------------
`default_nettype none
`include "counting_semaphore_table_unit_assert.svh"

module csem_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire csem_pkg::csem_sts_type sts,
   output csem_pkg::csem_cmd_type     cmd
);

   csem_pkg::csem_state_type state_ff;
   csem_pkg::csem_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csem_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         csem_pkg::S_IDLE: begin
            if (req_valid) state_in = csem_pkg::S_READ;
         end
         csem_pkg::S_READ: begin
            state_in = csem_pkg::S_EXEC;
         end
         csem_pkg::S_EXEC: begin
            if (sts.slot_free) state_in = csem_pkg::S_IDLE;
         end
         default: begin
            state_in = csem_pkg::S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_stall  = 1'b1;
      cmd.load   = 1'b0;
      cmd.scan   = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         csem_pkg::S_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         csem_pkg::S_READ: begin
            cmd.scan = 1'b1;
         end
         csem_pkg::S_EXEC: begin
            cmd.commit = sts.slot_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   `CSEM_ASSERT_NEXT(a_load_then_scan, clock, reset, cmd.load, cmd.scan)
   `CSEM_ASSERT_NEXT(a_accept_then_busy, clock, reset, req_valid && !req_stall, req_stall)
   `CSEM_ASSERT_NOW(a_commit_needs_slot, clock, reset, cmd.commit, sts.slot_free && req_stall)

endmodule

`default_nettype wire

>>> src/csem_free_enc.sv
// ----------------------------------------------------------------------------
// csem_free_enc
// two-stage priority encoder for the lowest inactive entry
// ----------------------------------------------------------------------------
`default_nettype none

module csem_free_enc #(
   parameter int SEM_COUNT = 64
) (
   input  wire logic                         clock,
   input  wire logic                         scan,
   input  wire logic [SEM_COUNT-1:0]         active,
   output logic                              found,
   output logic [$clog2(SEM_COUNT)-1:0]      free_idx
);

   localparam int IDX_W    = $clog2(SEM_COUNT);
   localparam int GRP_SIZE = 1 << csem_pkg::GRP_BITS;
   localparam int NGRP     = (SEM_COUNT + GRP_SIZE - 1) / GRP_SIZE;
   localparam int NGB      = (NGRP > 1) ? $clog2(NGRP) : 1;

   logic [NGRP*GRP_SIZE-1:0]       act_pad;
   logic [NGRP-1:0]                grp_free_in;
   logic [NGRP-1:0]                grp_free_ff;
   logic [csem_pkg::GRP_BITS-1:0]  grp_off_in [NGRP];
   logic [csem_pkg::GRP_BITS-1:0]  grp_off_ff [NGRP];
   logic [NGB-1:0]                 gsel;
   logic [csem_pkg::GRP_BITS-1:0]  off_sel;
   logic [NGB+csem_pkg::GRP_BITS-1:0] full_idx;

   // first stage: lowest free slot inside each group, padding counts as busy
   always_comb begin
      act_pad = '1;
      act_pad[SEM_COUNT-1:0] = active;
      for (int g = 0; g < NGRP; g++) begin
         grp_free_in[g] = 1'b0;
         grp_off_in[g]  = '0;
         for (int b = GRP_SIZE - 1; b >= 0; b--) begin
            if (!act_pad[g*GRP_SIZE + b]) begin
               grp_free_in[g] = 1'b1;
               grp_off_in[g]  = csem_pkg::GRP_BITS'(b);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (scan) begin
         grp_free_ff <= grp_free_in;
         grp_off_ff  <= grp_off_in;
      end
   end

   // second stage: lowest group with a free slot
   always_comb begin
      found   = 1'b0;
      gsel    = '0;
      off_sel = '0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (grp_free_ff[g]) begin
            found   = 1'b1;
            gsel    = NGB'(g);
            off_sel = grp_off_ff[g];
         end
      end
      full_idx = {gsel, off_sel};
      free_idx = IDX_W'(full_idx);
   end

endmodule

`default_nettype wire

>>> src/csem_dpath.sv
// ----------------------------------------------------------------------------
// csem_dpath
// count memory, active bits, command decode and result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "counting_semaphore_table_unit_assert.svh"

module csem_dpath #(
   parameter int SEM_COUNT  = 64,
   parameter int COUNT_BITS = 15
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire csem_pkg::csem_cmd_type cmd,
   output csem_pkg::csem_sts_type      sts,
   input  wire logic [2:0]             req_func,
   input  wire logic [7:0]             req_sem_index,
   input  wire logic signed [15:0]     req_init_value,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic [5:0]                  rsp_alloc_index,
   output logic                        rsp_wake,
   output logic [14:0]                 rsp_count_after
);

   localparam int IDX_W = $clog2(SEM_COUNT);
   localparam int RNG_W = $clog2(SEM_COUNT + 1);
   localparam int EXT_W = (RNG_W > 8) ? RNG_W : 8;
   localparam int AW    = (IDX_W > 6) ? IDX_W : 6;
   localparam int CW    = (COUNT_BITS > 15) ? COUNT_BITS : 15;

   // latched request
   logic [2:0]            func_ff;
   logic                  in_range_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [15:0]           init_ff;
   logic [EXT_W-1:0]      idx_ext;

   // table state
   logic [COUNT_BITS-1:0] count_mem [SEM_COUNT];
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic [SEM_COUNT-1:0]  active_ff;
   logic                  act_ff;

   // free search
   logic                  found;
   logic [IDX_W-1:0]      free_idx;

   // commit decode
   csem_pkg::csem_status_type status_c;
   logic [IDX_W-1:0]      alloc_c;
   logic                  wake_c;
   logic [COUNT_BITS-1:0] cnt_c;
   logic                  wr_en;
   logic [IDX_W-1:0]      act_addr;
   logic [COUNT_BITS-1:0] wr_data;
   logic                  set_act;
   logic                  clr_act;
   logic                  v_ok;
   logic [COUNT_BITS-1:0] open_cnt;
   logic [COUNT_BITS-1:0] cnt_max;
   logic [AW-1:0]         alloc_wide;
   logic [CW-1:0]         cnt_wide;

   // result register
   logic                  rsp_valid_ff;
   logic [1:0]            rsp_status_ff;
   logic [5:0]            rsp_alloc_ff;
   logic                  rsp_wake_ff;
   logic [14:0]           rsp_cnt_ff;

   assign idx_ext = EXT_W'(req_sem_index);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff     <= req_func;
         in_range_ff <= idx_ext < EXT_W'(SEM_COUNT);
         idx_ff      <= idx_ext[IDX_W-1:0];
         init_ff     <= req_init_value;
         rd_data_ff  <= count_mem[idx_ext[IDX_W-1:0]];
      end
      if (cmd.scan) begin
         act_ff <= active_ff[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         count_mem[act_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (cmd.commit) begin
         if (set_act) active_ff[act_addr] <= 1'b1;
         if (clr_act) active_ff[act_addr] <= 1'b0;
      end
   end

   csem_free_enc #(
      .SEM_COUNT (SEM_COUNT)
   ) u_free_enc (
      .clock    (clock),
      .scan     (cmd.scan),
      .active   (active_ff),
      .found    (found),
      .free_idx (free_idx)
   );

   assign cnt_max  = '1;
   assign open_cnt = COUNT_BITS'(init_ff[14:0]);
   assign v_ok     = !init_ff[15] && (CW'(init_ff[14:0]) <= CW'(cnt_max));

   always_comb begin
      status_c = csem_pkg::ST_ERR;
      alloc_c  = '0;
      wake_c   = 1'b0;
      cnt_c    = '0;
      wr_en    = 1'b0;
      wr_data  = open_cnt;
      act_addr = idx_ff;
      set_act  = 1'b0;
      clr_act  = 1'b0;
      case (csem_pkg::csem_func_type'(func_ff))
         csem_pkg::FN_OPEN: begin
            if (in_range_ff) begin
               if (act_ff) begin
                  cnt_c = rd_data_ff;
               end else if (v_ok) begin
                  set_act  = 1'b1;
                  wr_en    = 1'b1;
                  status_c = csem_pkg::ST_OK;
                  cnt_c    = open_cnt;
               end
            end
         end
         csem_pkg::FN_CLOSE: begin
            if (in_range_ff && act_ff) begin
               clr_act  = 1'b1;
               wake_c   = 1'b1;
               status_c = csem_pkg::ST_OK;
            end
         end
         csem_pkg::FN_UP: begin
            if (in_range_ff && act_ff) begin
               if (rd_data_ff != cnt_max) begin
                  wr_en    = 1'b1;
                  wr_data  = rd_data_ff + 1'b1;
                  wake_c   = (rd_data_ff == '0);
                  status_c = csem_pkg::ST_OK;
                  cnt_c    = rd_data_ff + 1'b1;
               end else begin
                  cnt_c = rd_data_ff;
               end
            end
         end
         csem_pkg::FN_DOWN: begin
            if (in_range_ff && act_ff) begin
               if (rd_data_ff == '0) begin
                  status_c = csem_pkg::ST_BLOCK;
               end else begin
                  wr_en    = 1'b1;
                  wr_data  = rd_data_ff - 1'b1;
                  status_c = csem_pkg::ST_OK;
                  cnt_c    = rd_data_ff - 1'b1;
               end
            end
         end
         csem_pkg::FN_OPEN_FREE: begin
            if (found && v_ok) begin
               act_addr = free_idx;
               set_act  = 1'b1;
               wr_en    = 1'b1;
               status_c = csem_pkg::ST_OK;
               alloc_c  = free_idx;
               cnt_c    = open_cnt;
            end
         end
         default: begin
            status_c = csem_pkg::ST_ERR;
         end
      endcase
   end

   assign alloc_wide = AW'(alloc_c);
   assign cnt_wide   = CW'(cnt_c);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff <= status_c;
         rsp_alloc_ff  <= alloc_wide[5:0];
         rsp_wake_ff   <= wake_c;
         rsp_cnt_ff    <= cnt_wide[14:0];
      end
   end

   assign sts.slot_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_alloc_index = rsp_alloc_ff;
   assign rsp_wake        = rsp_wake_ff;
   assign rsp_count_after = rsp_cnt_ff;

   `CSEM_ASSERT_NEXT(a_commit_shows_word, clock, reset, cmd.commit, rsp_valid_ff)
   `CSEM_ASSERT_NEXT(a_open_sets_active, clock, reset, cmd.commit && set_act, active_ff[$past(act_addr)])
   `CSEM_ASSERT_NOW(a_fail_keeps_table, clock, reset, cmd.commit && (status_c != csem_pkg::ST_OK), !wr_en && !set_act && !clr_act)

endmodule

`default_nettype wire

>>> src/counting_semaphore_table_unit.sv
// ----------------------------------------------------------------------------
// counting_semaphore_table_unit: table of counting semaphores
// commands run one at a time (accept, count read plus group search, execute)
// requests stall until execute loads the result word into a free result register
// reset clears all active bits and the sequencer; counts are undefined until opened
// ----------------------------------------------------------------------------
`default_nettype none

module counting_semaphore_table_unit #(
   parameter int SEM_COUNT  = 64,
   parameter int COUNT_BITS = 15
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_func,
   input  wire logic [7:0]         req_sem_index,
   input  wire logic signed [15:0] req_init_value,
   // result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [5:0]              rsp_alloc_index,
   output logic                    rsp_wake,
   output logic [14:0]             rsp_count_after
);

   // command strobes from the sequencer and the result slot status back
   csem_pkg::csem_cmd_type cmd;
   csem_pkg::csem_sts_type sts;

   // sequencer: idle takes a request word and starts the count read, read
   // samples the active bit and the first encoder stage, exec commits once the
   // result register is free (a waiting result does not block the next accept)
   csem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: count memory with registered read, active bit vector,
   // lowest-free search and the result register
   csem_dpath #(
      .SEM_COUNT  (SEM_COUNT),
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_func        (req_func),
      .req_sem_index   (req_sem_index),
      .req_init_value  (req_init_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_alloc_index (rsp_alloc_index),
      .rsp_wake        (rsp_wake),
      .rsp_count_after (rsp_count_after)
   );

endmodule

`default_nettype wire
